// ===== src/mep_pkg.sv =====
package mep_pkg;

   // number format: signed Q4.28 in a 32-bit word
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 28;

   // escape radius squared, 4.0 in Q8.56
   localparam logic [63:0] ESCAPE_SQ = 64'd1 << 58;

   // RGBA colors
   localparam logic [31:0] COLOR_INSIDE  = 32'h00FF00FF;
   localparam logic [31:0] COLOR_OUTSIDE = 32'hFF0000FF;

   // register indexes
   localparam logic [1:0] REG_REAL_MIN = 2'd0;
   localparam logic [1:0] REG_REAL_MAX = 2'd1;
   localparam logic [1:0] REG_IMAG_MIN = 2'd2;
   localparam logic [1:0] REG_IMAG_MAX = 2'd3;

   // register reset values, -2.0 and +2.0
   localparam logic signed [31:0] RST_MIN = -32'sd536870912;
   localparam logic signed [31:0] RST_MAX = 32'sd536870912;

   // clamp a wide signed value into the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -48'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ===== src/mandelbrot_escape_pixel.sv =====
// Mandelbrot escape-time evaluator, one pixel coordinate per word.
// Steps from accept to rsp_tvalid: reciprocal step multiply, map, clamp,
// then per escape test (1 .. ITER_LIMIT+1 tests) a multiply and an update
// on the shared multiplier set, then the load of the result register.
// A new pixel is taken only once the last one is in the result register,
// held up while an untaken result word holds it. Reset is synchronous: view to +/-2.0.
module mandelbrot_escape_pixel
   import mep_pkg::*;
#(
   parameter int ITER_LIMIT = 64,
   parameter int IMG_WIDTH  = 1024,
   parameter int IMG_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_col[9:0], pixel_row[19:10], zero pad
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_col[9:0], out_row[19:10],
                                    // pixel_color[51:20], zero pad
   output logic        rsp_tuser,   // in_set[0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW   = $clog2(ITER_LIMIT + 1);
   localparam int SH_R = WORD_BITS + $clog2(IMG_WIDTH);
   localparam int SH_I = WORD_BITS + $clog2(IMG_HEIGHT);

   // ceil(2^SH / size): exact floor quotient for any 32-bit span magnitude
   localparam logic [64:0] RCP_R_FULL =
      ((65'd1 << SH_R) + 65'(IMG_WIDTH - 1)) / 65'(IMG_WIDTH);
   localparam logic [64:0] RCP_I_FULL =
      ((65'd1 << SH_I) + 65'(IMG_HEIGHT - 1)) / 65'(IMG_HEIGHT);
   localparam logic [32:0] RCP_R = RCP_R_FULL[32:0];
   localparam logic [32:0] RCP_I = RCP_I_FULL[32:0];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MAP,
      ST_SAT,
      ST_MUL,
      ST_CHK,
      ST_FIN
   } state_type;

   // control
   state_type state_ff, state_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic rsp_valid_ff, rsp_valid_in;

   // view registers
   logic signed [31:0] real_min_ff, real_min_in;
   logic signed [31:0] real_max_ff, real_max_in;
   logic signed [31:0] imag_min_ff, imag_min_in;
   logic signed [31:0] imag_max_ff, imag_max_in;

   // pixel payload
   logic [9:0] col_ff, col_in;
   logic [9:0] row_ff, row_in;

   // span magnitude, then step magnitude
   logic [31:0]   quo_r_ff, quo_r_in;
   logic [31:0]   quo_i_ff, quo_i_in;
   logic          neg_r_ff, neg_r_in;
   logic          neg_i_ff, neg_i_in;

   // mapped point
   logic signed [42:0] map_r_ff, map_r_in;
   logic signed [42:0] map_i_ff, map_i_in;
   logic signed [31:0] cr_ff, cr_in;
   logic signed [31:0] ci_ff, ci_in;

   // iteration
   logic signed [31:0] zr_ff, zr_in;
   logic signed [31:0] zi_ff, zi_in;
   logic [62:0]        rr_ff, rr_in;
   logic [62:0]        ii_ff, ii_in;
   logic signed [63:0] cross_ff, cross_in;

   // result register
   logic [9:0] out_col_ff, out_col_in;
   logic [9:0] out_row_ff, out_row_in;
   logic       in_set_ff, in_set_in;
   logic       inside_ff, inside_in;

   // combinational helpers
   logic signed [32:0] diff_r, diff_i;
   logic signed [32:0] step_r, step_i;
   logic [64:0]        prod_r, prod_i;
   logic signed [63:0] sq_r, sq_i, xp;
   logic [63:0]        mag;
   logic signed [63:0] sq_diff;
   logic signed [39:0] nr_sum, ni_sum;
   logic               req_hs;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_hs     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = in_set_ff;
   assign rsp_tdata  = {4'd0, (in_set_ff ? COLOR_INSIDE : COLOR_OUTSIDE),
                        out_row_ff, out_col_ff};

   // view span per axis, exact in 33 bits
   assign diff_r = {real_max_ff[31], real_max_ff} - {real_min_ff[31], real_min_ff};
   assign diff_i = {imag_max_ff[31], imag_max_ff} - {imag_min_ff[31], imag_min_ff};

   // span magnitude times reciprocal of the image size
   assign prod_r = 65'(quo_r_ff) * 65'(RCP_R);
   assign prod_i = 65'(quo_i_ff) * 65'(RCP_I);

   // signed step, truncated toward zero
   assign step_r = neg_r_ff ? -$signed({1'b0, quo_r_ff}) : $signed({1'b0, quo_r_ff});
   assign step_i = neg_i_ff ? -$signed({1'b0, quo_i_ff}) : $signed({1'b0, quo_i_ff});

   // shared multiplier set: both squares and the cross product
   assign sq_r = 64'(zr_ff) * 64'(zr_ff);
   assign sq_i = 64'(zi_ff) * 64'(zi_ff);
   assign xp   = 64'(zr_ff) * 64'(zi_ff);

   // escape test and next z from the registered products
   assign mag     = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign sq_diff = $signed({1'b0, rr_ff}) - $signed({1'b0, ii_ff});
   assign nr_sum  = 40'(sq_diff >>> FRAC_BITS) + 40'(cr_ff);
   assign ni_sum  = 40'(cross_ff >>> (FRAC_BITS - 1)) + 40'(ci_ff);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      real_min_in  = real_min_ff;
      real_max_in  = real_max_ff;
      imag_min_in  = imag_min_ff;
      imag_max_in  = imag_max_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      quo_r_in     = quo_r_ff;
      quo_i_in     = quo_i_ff;
      neg_r_in     = neg_r_ff;
      neg_i_in     = neg_i_ff;
      map_r_in     = map_r_ff;
      map_i_in     = map_i_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      cross_in     = cross_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      in_set_in    = in_set_ff;
      inside_in    = inside_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            REG_REAL_MIN: real_min_in = csr_data;
            REG_REAL_MAX: real_max_in = csr_data;
            REG_IMAG_MIN: imag_min_in = csr_data;
            REG_IMAG_MAX: imag_max_in = csr_data;
            default: ;
         endcase
      end

      // result word taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               col_in   = req_tdata[9:0];
               row_in   = req_tdata[19:10];
               neg_r_in = diff_r[32];
               neg_i_in = diff_i[32];
               quo_r_in = diff_r[32] ? 32'(-diff_r) : diff_r[31:0];
               quo_i_in = diff_i[32] ? 32'(-diff_i) : diff_i[31:0];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_r_in = 32'(prod_r >> SH_R);
            quo_i_in = 32'(prod_i >> SH_I);
            state_in = ST_MAP;
         end
         ST_MAP: begin
            map_r_in = 43'($signed({1'b0, col_ff})) * 43'(step_r);
            map_i_in = 43'($signed({1'b0, row_ff})) * 43'(step_i);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cr_in    = sat32(48'(map_r_ff) + 48'(real_min_ff));
            ci_in    = sat32(48'(map_i_ff) + 48'(imag_min_ff));
            zr_in    = '0;
            zi_in    = '0;
            iter_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            rr_in    = sq_r[62:0];
            ii_in    = sq_i[62:0];
            cross_in = xp;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (mag > ESCAPE_SQ) begin
               inside_in = 1'b0;
               state_in  = ST_FIN;
            end else begin
               zr_in = sat32(48'(nr_sum));
               zi_in = sat32(48'(ni_sum));
               if (iter_ff == IW'(ITER_LIMIT)) begin
                  inside_in = 1'b1;
                  state_in  = ST_FIN;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_FIN: begin
            // wait for the result register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               out_col_in   = col_ff;
               out_row_in   = row_ff;
               in_set_in    = inside_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, registers and result word
   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      row_ff     <= row_in;
      quo_r_ff   <= quo_r_in;
      quo_i_ff   <= quo_i_in;
      neg_r_ff   <= neg_r_in;
      neg_i_ff   <= neg_i_in;
      map_r_ff   <= map_r_in;
      map_i_ff   <= map_i_in;
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      rr_ff      <= rr_in;
      ii_ff      <= ii_in;
      cross_ff   <= cross_in;
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
      in_set_ff  <= in_set_in;
      inside_ff  <= inside_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         real_min_ff  <= RST_MIN;
         real_max_ff  <= RST_MAX;
         imag_min_ff  <= RST_MIN;
         imag_max_ff  <= RST_MAX;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         real_min_ff  <= real_min_in;
         real_max_ff  <= real_max_in;
         imag_min_ff  <= imag_min_in;
         imag_max_ff  <= imag_max_in;
      end
   end

endmodule
